>>> hw/rtl/aba_pkg.sv
// Shared types, widths, constants and helpers of the arena bump allocator unit.
package aba_pkg;

	// Field and state widths.
	localparam int unsigned OP_W      = 3;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned ALEN_W    = 33;
	localparam int unsigned CHUNK_W   = 16;
	localparam int unsigned OFF_W     = 33;
	localparam int unsigned TIP_W     = 34;
	localparam int unsigned TOT_W     = 48;
	localparam int unsigned CFG_W     = 33;

	// Stream payload widths, padded to whole bytes.
	localparam int unsigned IN_DATA_W  = 120;
	localparam int unsigned OUT_FLD_W  = 148;
	localparam int unsigned OUT_DATA_W = 152;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

	// Configuration port.
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 64;
	localparam logic        REG_INIT_CAP = 1'b0;
	localparam logic        REG_MAX_CAP  = 1'b1;
	localparam logic [CFG_W-1:0] INIT_CAP_RST = CFG_W'(2048);
	localparam logic [CFG_W-1:0] MAX_CAP_RST  = CFG_W'(16777216);

	// Alignment and the remainder unit: the operand is fed one byte per step.
	localparam int unsigned ALIGNMENT_DEF = 8;
	localparam int unsigned REM_STEPS     = 5;
	localparam int unsigned REM_SR_W      = REM_STEPS * 8;
	localparam int unsigned STEP_W        = $clog2(REM_STEPS);

	localparam logic [TOT_W-1:0] SAT48   = {TOT_W{1'b1}};
	localparam logic [TIP_W-1:0] TIP_MAX = {TIP_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC      = 3'd0,
		OP_REALLOC    = 3'd1,
		OP_ALLOC_AL   = 3'd2,
		OP_REALLOC_AL = 3'd3,
		OP_RESET      = 3'd4,
		OP_DESTROY    = 3'd5
	} op_e;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_REM_STEP,
		CMD_TIP_APPLY,
		CMD_REM_LEN,
		CMD_LEN_APPLY,
		CMD_SAME,
		CMD_SHRINK,
		CMD_GROW,
		CMD_MARK_COPY,
		CMD_CAP_INIT,
		CMD_CAP_DOUBLE,
		CMD_OPEN,
		CMD_PLACE,
		CMD_RESET,
		CMD_DESTROY,
		CMD_EMIT
	} cmd_e;

	typedef struct packed {
		op_e  op;
		logic have;
		logic fits;
		logic at_tip;
		logic len_eq;
		logic len_lt;
		logic grow_fits;
		logic cap_lt_len;
	} status_t;

	// Saturating add onto a 48-bit total.
	function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] t,
		input logic [TIP_W:0] d);
		logic [TOT_W:0] s;
		s = {1'b0, t} + (TOT_W+1)'(d);
		return (s >= {1'b0, SAT48}) ? SAT48 : s[TOT_W-1:0];
	endfunction

endpackage

>>> hw/rtl/aba_ctrl.sv
// Sequencer of the arena bump allocator: walks each request through the datapath.
module aba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  aba_pkg::status_t  st,
	output aba_pkg::cmd_e     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TIP_REM,
		ST_TIP_APPLY,
		ST_LEN_LOAD,
		ST_LEN_REM,
		ST_LEN_APPLY,
		ST_EXEC,
		ST_CAP_INIT,
		ST_CAP_GROW,
		ST_PLACE,
		ST_FINISH
	} state_t;

	state_t                       state_q;
	state_t                       state_d;
	logic [aba_pkg::STEP_W-1:0]   step_q;
	logic                         m_tvalid_q;
	logic                         step_last;
	logic                         in_rem;

	assign step_last = (step_q == aba_pkg::STEP_W'(aba_pkg::REM_STEPS - 1));
	assign in_rem    = (state_q == ST_TIP_REM) || (state_q == ST_LEN_REM);
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd     = aba_pkg::CMD_NONE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd     = aba_pkg::CMD_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (st.op inside {aba_pkg::OP_ALLOC_AL, aba_pkg::OP_REALLOC_AL}) begin
					state_d = st.have ? ST_TIP_REM : ST_LEN_LOAD;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_TIP_REM: begin
				cmd = aba_pkg::CMD_REM_STEP;
				if (step_last) state_d = ST_TIP_APPLY;
			end
			ST_TIP_APPLY: begin
				cmd     = aba_pkg::CMD_TIP_APPLY;
				state_d = ST_LEN_REM;
			end
			ST_LEN_LOAD: begin
				cmd     = aba_pkg::CMD_REM_LEN;
				state_d = ST_LEN_REM;
			end
			ST_LEN_REM: begin
				cmd = aba_pkg::CMD_REM_STEP;
				if (step_last) state_d = ST_LEN_APPLY;
			end
			ST_LEN_APPLY: begin
				cmd     = aba_pkg::CMD_LEN_APPLY;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (st.op)
					aba_pkg::OP_ALLOC, aba_pkg::OP_ALLOC_AL: begin
						state_d = st.fits ? ST_PLACE : ST_CAP_INIT;
					end
					aba_pkg::OP_REALLOC, aba_pkg::OP_REALLOC_AL: begin
						if (st.len_eq) begin
							cmd     = aba_pkg::CMD_SAME;
							state_d = ST_FINISH;
						end else if (st.at_tip && st.len_lt) begin
							cmd     = aba_pkg::CMD_SHRINK;
							state_d = ST_FINISH;
						end else if (st.at_tip && st.grow_fits) begin
							cmd     = aba_pkg::CMD_GROW;
							state_d = ST_FINISH;
						end else begin
							cmd     = aba_pkg::CMD_MARK_COPY;
							state_d = st.fits ? ST_PLACE : ST_CAP_INIT;
						end
					end
					aba_pkg::OP_RESET: begin
						cmd     = aba_pkg::CMD_RESET;
						state_d = ST_FINISH;
					end
					aba_pkg::OP_DESTROY: begin
						cmd     = aba_pkg::CMD_DESTROY;
						state_d = ST_FINISH;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_CAP_INIT: begin
				cmd     = aba_pkg::CMD_CAP_INIT;
				state_d = ST_CAP_GROW;
			end
			ST_CAP_GROW: begin
				if (st.cap_lt_len) begin
					cmd = aba_pkg::CMD_CAP_DOUBLE;
				end else begin
					cmd     = aba_pkg::CMD_OPEN;
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd     = aba_pkg::CMD_PLACE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					cmd     = aba_pkg::CMD_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_rem && !step_last) step_q <= step_q + 1'b1;
			else step_q <= '0;
			if (cmd == aba_pkg::CMD_EMIT) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/aba_dp.sv
// Datapath of the arena bump allocator: head chunk state, totals, remainder unit, result.
module aba_dp #(
	parameter int unsigned ALIGNMENT = aba_pkg::ALIGNMENT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  aba_pkg::cmd_e                     cmd,
	output aba_pkg::status_t                  st,
	input  logic [aba_pkg::OP_W-1:0]          in_op,
	input  logic [aba_pkg::LEN_W-1:0]         in_length,
	input  logic [aba_pkg::LEN_W-1:0]         in_old_length,
	input  logic [aba_pkg::CHUNK_W-1:0]       in_old_chunk,
	input  logic [aba_pkg::OFF_W-1:0]         in_old_offset,
	input  logic [aba_pkg::CFG_W-1:0]         base_cap,
	input  logic [aba_pkg::CFG_W-1:0]         max_capacity,
	output logic [aba_pkg::OUT_DATA_W-1:0]    out_data
);

	localparam int unsigned RW = (ALIGNMENT > 1) ? $clog2(ALIGNMENT) : 1;
	localparam logic [RW:0] ALIGN_V = (RW+1)'(ALIGNMENT);

	// Architectural state.
	logic                              have_q;
	logic [aba_pkg::TIP_W-1:0]         tip_q;
	logic [aba_pkg::TIP_W-1:0]         size_q;
	logic [aba_pkg::CHUNK_W-1:0]       serial_q;
	logic [aba_pkg::TOT_W-1:0]         alloc_q;
	logic [aba_pkg::TOT_W-1:0]         used_q;

	// Per-request working registers.
	aba_pkg::op_e                      op_q;
	logic [aba_pkg::ALEN_W-1:0]        len_q;
	logic [aba_pkg::LEN_W-1:0]         old_len_q;
	logic [aba_pkg::CHUNK_W-1:0]       old_chunk_q;
	logic [aba_pkg::OFF_W-1:0]         old_off_q;
	logic [aba_pkg::TIP_W-1:0]         cap_q;
	logic [aba_pkg::REM_SR_W-1:0]      rem_sr_q;
	logic [RW-1:0]                     rem_q;
	logic [aba_pkg::CHUNK_W-1:0]       res_chunk_q;
	logic [aba_pkg::OFF_W-1:0]         res_off_q;
	logic                              res_open_q;
	logic                              res_copy_q;
	logic [aba_pkg::OUT_DATA_W-1:0]    out_data_q;

	// Combinational terms.
	logic [aba_pkg::TIP_W:0]           tip_plus_len;
	logic [aba_pkg::ALEN_W-1:0]        old_len_x;
	logic [aba_pkg::ALEN_W-1:0]        grow_d;
	logic [aba_pkg::TIP_W:0]           grow_sum;
	logic [aba_pkg::ALEN_W-1:0]        shrink_d;
	logic [aba_pkg::TIP_W-1:0]         shrink_delta;
	logic [aba_pkg::TOT_W-1:0]         used_after_shrink;
	logic [RW-1:0]                     rem_next;
	logic [RW:0]                       pad;
	logic [aba_pkg::TIP_W:0]           tip_round_raw;
	logic [aba_pkg::TIP_W-1:0]         tip_round;
	logic [aba_pkg::TIP_W-1:0]         cap_init;

	assign old_len_x    = {1'b0, old_len_q};
	assign tip_plus_len = {1'b0, tip_q} + (aba_pkg::TIP_W+1)'(len_q);
	assign grow_d       = len_q - old_len_x;
	assign grow_sum     = {1'b0, tip_q} + (aba_pkg::TIP_W+1)'(grow_d);
	assign shrink_d     = old_len_x - len_q;

	assign st.op         = op_q;
	assign st.have       = have_q;
	assign st.fits       = have_q && (tip_plus_len <= {1'b0, size_q});
	assign st.at_tip     = have_q && (old_chunk_q == serial_q) && ({1'b0, old_off_q} == tip_q);
	assign st.len_eq     = (len_q == old_len_x);
	assign st.len_lt     = (len_q < old_len_x);
	assign st.grow_fits  = (grow_sum <= {1'b0, size_q});
	assign st.cap_lt_len = (cap_q < aba_pkg::TIP_W'(len_q));

	// A shrink lowers the tip by at most the tip itself; the used total follows.
	always_comb begin
		if (tip_q >= aba_pkg::TIP_W'(shrink_d)) shrink_delta = aba_pkg::TIP_W'(shrink_d);
		else shrink_delta = tip_q;
		if (used_q == aba_pkg::SAT48) used_after_shrink = used_q;
		else if (used_q >= aba_pkg::TOT_W'(shrink_delta))
			used_after_shrink = used_q - aba_pkg::TOT_W'(shrink_delta);
		else used_after_shrink = '0;
	end

	// One byte of the operand per step, most significant first.
	always_comb begin
		logic [RW:0]   t;
		logic [RW-1:0] r;
		logic [7:0]    b;
		r = rem_q;
		b = rem_sr_q[aba_pkg::REM_SR_W-1 -: 8];
		for (int i = 7; i >= 0; i--) begin
			t = {r, b[i]};
			if (t >= ALIGN_V) t = t - ALIGN_V;
			r = t[RW-1:0];
		end
		rem_next = r;
	end

	// Padding that rounds the last operand up to the alignment.
	assign pad = (rem_q == '0) ? '0 : (ALIGN_V - {1'b0, rem_q});
	assign tip_round_raw = {1'b0, tip_q} + (aba_pkg::TIP_W+1)'(pad);
	assign tip_round = (tip_round_raw > {1'b0, aba_pkg::TIP_MAX}) ? aba_pkg::TIP_MAX :
		tip_round_raw[aba_pkg::TIP_W-1:0];

	// Base size of a new chunk before doubling to fit.
	always_comb begin
		logic [aba_pkg::TIP_W-1:0] max_x;
		max_x    = aba_pkg::TIP_W'(max_capacity);
		cap_init = have_q ? size_q : aba_pkg::TIP_W'(base_cap);
		if (cap_init > max_x) cap_init = max_x;
		if (cap_init == '0) cap_init = aba_pkg::TIP_W'(1);
		if (cap_init < max_x) cap_init = cap_init << 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			tip_q    <= '0;
			size_q   <= '0;
			serial_q <= '0;
			alloc_q  <= '0;
			used_q   <= '0;
		end else begin
			case (cmd)
				aba_pkg::CMD_TIP_APPLY: begin
					used_q <= aba_pkg::sat_add(used_q,
						(aba_pkg::TIP_W+1)'(tip_round - tip_q));
					tip_q  <= tip_round;
				end
				aba_pkg::CMD_SHRINK: begin
					tip_q  <= tip_q - shrink_delta;
					used_q <= used_after_shrink;
				end
				aba_pkg::CMD_GROW: begin
					tip_q  <= grow_sum[aba_pkg::TIP_W-1:0];
					used_q <= aba_pkg::sat_add(used_q, (aba_pkg::TIP_W+1)'(grow_d));
				end
				aba_pkg::CMD_OPEN: begin
					have_q   <= 1'b1;
					serial_q <= serial_q + 1'b1;
					size_q   <= cap_q;
					tip_q    <= '0;
					alloc_q  <= aba_pkg::sat_add(alloc_q, (aba_pkg::TIP_W+1)'(cap_q));
				end
				aba_pkg::CMD_PLACE: begin
					tip_q  <= tip_plus_len[aba_pkg::TIP_W-1:0];
					used_q <= aba_pkg::sat_add(used_q, (aba_pkg::TIP_W+1)'(len_q));
				end
				aba_pkg::CMD_RESET: begin
					if (have_q) tip_q <= '0;
					alloc_q <= '0;
					used_q  <= '0;
				end
				aba_pkg::CMD_DESTROY: begin
					have_q  <= 1'b0;
					tip_q   <= '0;
					size_q  <= '0;
					alloc_q <= '0;
					used_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			aba_pkg::CMD_LOAD: begin
				op_q        <= aba_pkg::op_e'(in_op);
				len_q       <= aba_pkg::ALEN_W'(in_length);
				old_len_q   <= in_old_length;
				old_chunk_q <= in_old_chunk;
				old_off_q   <= in_old_offset;
				rem_sr_q    <= aba_pkg::REM_SR_W'(tip_q);
				rem_q       <= '0;
				res_chunk_q <= '0;
				res_off_q   <= '0;
				res_open_q  <= 1'b0;
				res_copy_q  <= 1'b0;
			end
			aba_pkg::CMD_REM_STEP: begin
				rem_q    <= rem_next;
				rem_sr_q <= rem_sr_q << 8;
			end
			aba_pkg::CMD_TIP_APPLY, aba_pkg::CMD_REM_LEN: begin
				rem_sr_q <= aba_pkg::REM_SR_W'(len_q);
				rem_q    <= '0;
			end
			aba_pkg::CMD_LEN_APPLY: begin
				len_q <= len_q + aba_pkg::ALEN_W'(pad);
			end
			aba_pkg::CMD_SAME, aba_pkg::CMD_SHRINK, aba_pkg::CMD_GROW: begin
				res_chunk_q <= old_chunk_q;
				res_off_q   <= old_off_q;
			end
			aba_pkg::CMD_MARK_COPY: begin
				res_copy_q <= 1'b1;
			end
			aba_pkg::CMD_CAP_INIT: begin
				cap_q <= cap_init;
			end
			aba_pkg::CMD_CAP_DOUBLE: begin
				cap_q <= cap_q << 1;
			end
			aba_pkg::CMD_OPEN: begin
				res_open_q <= 1'b1;
			end
			aba_pkg::CMD_PLACE: begin
				res_chunk_q <= serial_q;
				res_off_q   <= tip_q[aba_pkg::OFF_W-1:0];
			end
			aba_pkg::CMD_EMIT: begin
				out_data_q <= {{aba_pkg::OUT_PAD_W{1'b0}}, !have_q, used_q, alloc_q,
					res_copy_q, res_open_q, res_off_q, res_chunk_q};
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_data_q;

endmodule

>>> hw/rtl/arena_bump_allocator_unit.sv
// Top level of the arena bump allocator: stream ports, configuration registers, core.
// One request is worked at a time. A reallocation in place, reset or destroy finishes
// directly; a placement goes into the head chunk or first opens one, doubling its size
// to fit. Aligned requests pass the byte-wide remainder unit, which rounds tip and
// length (only the length with no chunk). The next request can be taken in the cycle
// after the result is loaded. Reset clears all allocator state and the configuration to
// its defaults (initial size 2048, maximum size 16777216); there is no clearing pass.
module arena_bump_allocator_unit #(
	parameter int unsigned ALIGNMENT = aba_pkg::ALIGNMENT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Request stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: length[31:0], old_length[63:32], old_chunk[79:64],
	// old_offset[112:80], zero pad.
	input  logic [aba_pkg::IN_DATA_W-1:0]      s_tdata,
	// Fields: op[2:0].
	input  logic [aba_pkg::OP_W-1:0]           s_tuser,
	// Result stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// Fields from bit 0: chunk_id[15:0], offset[48:16], opened_chunk[49], copy_needed[50],
	// bytes_allocated[98:51], bytes_used[146:99], empty_res[147], zero pad.
	output logic [aba_pkg::OUT_DATA_W-1:0]     m_tdata,
	// Configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [aba_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [aba_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [aba_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	logic [aba_pkg::CFG_W-1:0] init_cap_q;
	logic [aba_pkg::CFG_W-1:0] max_cap_q;
	logic                      cfg_wr;
	logic                      reg_sel;
	aba_pkg::status_t          st;
	aba_pkg::cmd_e             cmd;

	// Registers sit at byte addresses 0 and 8; bit 3 of the address picks one.
	assign pready  = 1'b1;
	assign reg_sel = paddr[3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cap_q <= aba_pkg::INIT_CAP_RST;
			max_cap_q  <= aba_pkg::MAX_CAP_RST;
		end else if (cfg_wr) begin
			if (reg_sel == aba_pkg::REG_INIT_CAP) init_cap_q <= pwdata[aba_pkg::CFG_W-1:0];
			else max_cap_q <= pwdata[aba_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		if (reg_sel == aba_pkg::REG_MAX_CAP) prdata = aba_pkg::APB_DATA_W'(max_cap_q);
		else prdata = aba_pkg::APB_DATA_W'(init_cap_q);
	end

	// The controller walks each beat through the datapath, at most one command per cycle.
	aba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// The datapath holds the head chunk, the totals and the result register.
	aba_dp #(
		.ALIGNMENT (ALIGNMENT)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.in_op            (s_tuser),
		.in_length        (s_tdata[31:0]),
		.in_old_length    (s_tdata[63:32]),
		.in_old_chunk     (s_tdata[79:64]),
		.in_old_offset    (s_tdata[112:80]),
		.base_cap         (init_cap_q),
		.max_capacity     (max_cap_q),
		.out_data         (m_tdata)
	);

endmodule
